>>> src/rsd_pkg.sv
// ----------------------------------------------------------------------------
// rsd_pkg: shared types, widths and constants
// Axis and deadzone widths, register indexes and the sideband carried
// through the pipeline.
// ----------------------------------------------------------------------------
package rsd_pkg;

  localparam int AXIS_W    = 16;
  localparam int FRAC      = AXIS_W - 1;
  localparam int DZ_W      = 14;
  localparam int DZ_FRAC   = 15;
  localparam int NUM_W     = 2 * AXIS_W;
  localparam int QUO_W     = AXIS_W + 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_INNER = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_OUTER = CFG_IDX_W'(1);

  localparam logic [DZ_W-1:0] INNER_RST = DZ_W'(9830);
  localparam logic [DZ_W-1:0] OUTER_RST = DZ_W'(4915);

  localparam logic [AXIS_W-1:0] ONE = AXIS_W'(1) << FRAC;

  typedef struct packed {
    logic              sx;
    logic              sy;
    logic [AXIS_W-1:0] ax;
    logic [AXIS_W-1:0] ay;
    logic [AXIS_W-1:0] mag;
    logic [AXIS_W-1:0] norm;
    logic              dz;
  } side_t;

  function automatic logic [AXIS_W-1:0] dz_scale(logic [DZ_W-1:0] dz);
    logic [DZ_W+AXIS_W-2:0] t;
    logic [DZ_W+AXIS_W-2:0] s;
    t = (DZ_W+AXIS_W-1)'(dz) << FRAC;
    s = t >> DZ_FRAC;
    return s[AXIS_W-1:0];
  endfunction

endpackage

>>> src/rsd_sqrt.sv
// ----------------------------------------------------------------------------
// rsd_sqrt: pipelined integer square root
// One result bit per stage, remainder form, floor of the square root.
// ----------------------------------------------------------------------------
module rsd_sqrt (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [rsd_pkg::NUM_W-1:0]  rad_i,
  input  rsd_pkg::side_t             side_i,
  output logic                       valid_o,
  output logic [rsd_pkg::AXIS_W-1:0] root_o,
  output rsd_pkg::side_t             side_o
);

  localparam int NS = rsd_pkg::AXIS_W;
  localparam int CW = rsd_pkg::NUM_W + 1;

  logic                       vld_q  [NS+1];
  logic [rsd_pkg::NUM_W-1:0]  rem_q  [NS+1];
  logic [rsd_pkg::AXIS_W-1:0] root_q [NS+1];
  rsd_pkg::side_t             side_q [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= rad_i;
      root_q[0] <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar j = 1; j <= NS; j++) begin : g_step
    localparam int I = NS - j;
    logic [CW-1:0] trial;
    logic          fit;

    assign trial = (CW'(root_q[j-1]) << (I + 1)) + (CW'(1) << (2 * I));
    assign fit   = {1'b0, rem_q[j-1]} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= fit ? (rem_q[j-1] - trial[rsd_pkg::NUM_W-1:0]) : rem_q[j-1];
        root_q[j] <= root_q[j-1] | (rsd_pkg::AXIS_W'(fit) << I);
        side_q[j] <= side_q[j-1];
      end
    end
  end

  assign valid_o = vld_q[NS];
  assign root_o  = root_q[NS];
  assign side_o  = side_q[NS];

endmodule

>>> src/rsd_div.sv
// ----------------------------------------------------------------------------
// rsd_div: pipelined restoring divider
// One quotient bit per stage; flags a quotient too wide for the result.
// ----------------------------------------------------------------------------
module rsd_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  logic                       valid_i,
  input  logic [rsd_pkg::NUM_W-1:0]  num_i,
  input  logic [rsd_pkg::AXIS_W-1:0] den_i,
  input  rsd_pkg::side_t             side_i,
  output logic                       valid_o,
  output logic [rsd_pkg::QUO_W-1:0]  quo_o,
  output logic                       ovf_o,
  output rsd_pkg::side_t             side_o
);

  localparam int NS = rsd_pkg::QUO_W;
  localparam int CW = rsd_pkg::NUM_W + 1;

  logic                       vld_q  [NS+1];
  logic [rsd_pkg::NUM_W-1:0]  rem_q  [NS+1];
  logic [rsd_pkg::QUO_W-1:0]  quo_q  [NS+1];
  logic [rsd_pkg::AXIS_W-1:0] den_q  [NS+1];
  logic                       ovf_q  [NS+1];
  rsd_pkg::side_t             side_q [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0]  <= num_i;
      quo_q[0]  <= '0;
      den_q[0]  <= den_i;
      ovf_q[0]  <= {1'b0, num_i} >= (CW'(den_i) << NS);
      side_q[0] <= side_i;
    end
  end

  for (genvar j = 1; j <= NS; j++) begin : g_step
    localparam int K = NS - j;
    logic [CW-1:0] trial;
    logic          fit;

    assign trial = CW'(den_q[j-1]) << K;
    assign fit   = {1'b0, rem_q[j-1]} >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[j] <= 1'b0;
      end else if (en_i) begin
        vld_q[j] <= vld_q[j-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[j]  <= fit ? (rem_q[j-1] - trial[rsd_pkg::NUM_W-1:0]) : rem_q[j-1];
        quo_q[j]  <= quo_q[j-1] | (rsd_pkg::QUO_W'(fit) << K);
        den_q[j]  <= den_q[j-1];
        ovf_q[j]  <= ovf_q[j-1];
        side_q[j] <= side_q[j-1];
      end
    end
  end

  assign valid_o = vld_q[NS];
  assign quo_o   = quo_q[NS];
  assign ovf_o   = ovf_q[NS];
  assign side_o  = side_q[NS];

endmodule

>>> src/radial_stick_deadzone.sv
// ----------------------------------------------------------------------------
// radial_stick_deadzone: scaled radial deadzone for a two-axis stick
// Throughput: one sample per cycle; the pipeline advances while the
// two-entry output queue has room.
// Reset: clears all valid bits and the queue; both deadzone registers
// return to their defaults.
// ----------------------------------------------------------------------------
module radial_stick_deadzone (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [rsd_pkg::AXIS_W-1:0]    stick_x_i,
  input  logic [rsd_pkg::AXIS_W-1:0]    stick_y_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [rsd_pkg::AXIS_W-1:0]    out_x_o,
  output logic [rsd_pkg::AXIS_W-1:0]    out_y_o,
  output logic                          in_deadzone_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [rsd_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rsd_pkg::DZ_W-1:0]      cfg_data_i
);

  localparam int W  = rsd_pkg::AXIS_W;
  localparam int NW = rsd_pkg::NUM_W;
  localparam int QW = rsd_pkg::QUO_W;
  localparam logic [1:0] QDEPTH = 2'd2;

  typedef struct packed {
    logic [W-1:0] x;
    logic [W-1:0] y;
    logic         dz;
  } out_t;

  function automatic logic [W-1:0] sat_axis(logic neg, logic ovf, logic [QW-1:0] q);
    logic big;
    big = ovf || (q > QW'(rsd_pkg::ONE));
    if (neg) begin
      return big ? rsd_pkg::ONE : (~q[W-1:0] + 1'b1);
    end
    return (ovf || (q >= QW'(rsd_pkg::ONE))) ? (rsd_pkg::ONE - 1'b1) : q[W-1:0];
  endfunction

  logic [rsd_pkg::DZ_W-1:0] inner_q, outer_q;
  logic [W-1:0]             inner_s_q, range_q;
  logic [NW-1:0]            inner_sq_q;
  logic [W-1:0]             inner_s_d;

  assign cfg_ready_o = 1'b1;
  assign inner_s_d   = rsd_pkg::dz_scale(inner_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inner_q    <= rsd_pkg::INNER_RST;
      outer_q    <= rsd_pkg::OUTER_RST;
      inner_s_q  <= rsd_pkg::dz_scale(rsd_pkg::INNER_RST);
      range_q    <= rsd_pkg::ONE - rsd_pkg::dz_scale(rsd_pkg::OUTER_RST)
                    - rsd_pkg::dz_scale(rsd_pkg::INNER_RST);
      inner_sq_q <= NW'(rsd_pkg::dz_scale(rsd_pkg::INNER_RST))
                    * NW'(rsd_pkg::dz_scale(rsd_pkg::INNER_RST));
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          rsd_pkg::REG_INNER: inner_q <= cfg_data_i;
          rsd_pkg::REG_OUTER: outer_q <= cfg_data_i;
          default: ;
        endcase
      end
      inner_s_q  <= inner_s_d;
      range_q    <= rsd_pkg::ONE - rsd_pkg::dz_scale(outer_q) - inner_s_d;
      inner_sq_q <= NW'(inner_s_d) * NW'(inner_s_d);
    end
  end

  logic pipe_en;
  logic [1:0] cnt_q;

  assign pipe_en    = (cnt_q != QDEPTH);
  assign in_stall_o = !pipe_en;

  // abs
  logic s1_vld_q;
  rsd_pkg::side_t s1_q, s1_d;

  always_comb begin
    s1_d    = '0;
    s1_d.sx = stick_x_i[W-1];
    s1_d.sy = stick_y_i[W-1];
    s1_d.ax = stick_x_i[W-1] ? (~stick_x_i + 1'b1) : stick_x_i;
    s1_d.ay = stick_y_i[W-1] ? (~stick_y_i + 1'b1) : stick_y_i;
  end

  // squares
  logic s2_vld_q;
  rsd_pkg::side_t s2_q;
  logic [NW-1:0] s2_sqx_q, s2_sqy_q;

  // sum and deadzone test
  logic s3_vld_q;
  rsd_pkg::side_t s3_q, s3_d;
  logic [NW-1:0] s3_sum_q, s3_sum_d;

  assign s3_sum_d = s2_sqx_q + s2_sqy_q;
  always_comb begin
    s3_d    = s2_q;
    s3_d.dz = (s3_sum_d <= inner_sq_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
      s3_vld_q <= 1'b0;
    end else if (pipe_en) begin
      s1_vld_q <= in_valid_i;
      s2_vld_q <= s1_vld_q;
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s1_q     <= s1_d;
      s2_q     <= s1_q;
      s2_sqx_q <= NW'(s1_q.ax) * NW'(s1_q.ax);
      s2_sqy_q <= NW'(s1_q.ay) * NW'(s1_q.ay);
      s3_q     <= s3_d;
      s3_sum_q <= s3_sum_d;
    end
  end

  logic sq_vld;
  logic [W-1:0] sq_root;
  rsd_pkg::side_t sq_side;

  rsd_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s3_vld_q),
    .rad_i   (s3_sum_q),
    .side_i  (s3_q),
    .valid_o (sq_vld),
    .root_o  (sq_root),
    .side_o  (sq_side)
  );

  // magnitude above the inner radius
  logic s4_vld_q;
  rsd_pkg::side_t s4_q, s4_d;
  logic [W-1:0] s4_diff_q;

  always_comb begin
    s4_d     = sq_side;
    s4_d.mag = sq_root;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (pipe_en) begin
      s4_vld_q <= sq_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s4_q      <= s4_d;
      s4_diff_q <= sq_root - inner_s_q;
    end
  end

  logic nd_vld, nd_ovf;
  logic [QW-1:0] nd_quo;
  rsd_pkg::side_t nd_side;

  rsd_div u_norm_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s4_vld_q),
    .num_i   (NW'({s4_diff_q, {rsd_pkg::FRAC{1'b0}}})),
    .den_i   (range_q),
    .side_i  (s4_q),
    .valid_o (nd_vld),
    .quo_o   (nd_quo),
    .ovf_o   (nd_ovf),
    .side_o  (nd_side)
  );

  // cap the new magnitude, then scale both axes
  logic s5_vld_q, s6_vld_q;
  rsd_pkg::side_t s5_q, s5_d, s6_q;
  logic [NW-1:0] s6_px_q, s6_py_q;

  always_comb begin
    s5_d      = nd_side;
    s5_d.norm = (nd_ovf || (nd_quo > QW'(rsd_pkg::ONE))) ? rsd_pkg::ONE : nd_quo[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
      s6_vld_q <= 1'b0;
    end else if (pipe_en) begin
      s5_vld_q <= nd_vld;
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pipe_en) begin
      s5_q    <= s5_d;
      s6_q    <= s5_q;
      s6_px_q <= NW'(s5_q.ax) * NW'(s5_q.norm);
      s6_py_q <= NW'(s5_q.ay) * NW'(s5_q.norm);
    end
  end

  logic xd_vld, xd_ovf, yd_vld, yd_ovf;
  logic [QW-1:0] xd_quo, yd_quo;
  rsd_pkg::side_t xd_side, yd_side;

  rsd_div u_x_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s6_vld_q),
    .num_i   (s6_px_q),
    .den_i   (s6_q.mag),
    .side_i  (s6_q),
    .valid_o (xd_vld),
    .quo_o   (xd_quo),
    .ovf_o   (xd_ovf),
    .side_o  (xd_side)
  );

  rsd_div u_y_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (pipe_en),
    .valid_i (s6_vld_q),
    .num_i   (s6_py_q),
    .den_i   (s6_q.mag),
    .side_i  (s6_q),
    .valid_o (yd_vld),
    .quo_o   (yd_quo),
    .ovf_o   (yd_ovf),
    .side_o  (yd_side)
  );

  out_t res_d;
  always_comb begin
    res_d.dz = yd_side.dz;
    res_d.x  = yd_side.dz ? '0 : sat_axis(xd_side.sx, xd_ovf, xd_quo);
    res_d.y  = yd_side.dz ? '0 : sat_axis(yd_side.sy, yd_ovf, yd_quo);
  end

  // output queue
  out_t fifo_q [2];
  logic wr_q, rd_q;
  logic push, pop;

  assign push = xd_vld && yd_vld && pipe_en;
  assign pop  = (cnt_q != 2'd0) && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
    end else begin
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
      if (push) begin
        wr_q <= ~wr_q;
      end
      if (pop) begin
        rd_q <= ~rd_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_q] <= res_d;
    end
  end

  assign out_valid_o   = (cnt_q != 2'd0);
  assign out_x_o       = fifo_q[rd_q].x;
  assign out_y_o       = fifo_q[rd_q].y;
  assign in_deadzone_o = fifo_q[rd_q].dz;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QDEPTH)
    else $error("output queue overfilled");

  a_dz_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && in_deadzone_o |-> (out_x_o == '0) && (out_y_o == '0))
    else $error("deadzone beat carries nonzero axes");

  a_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pipe_en |=> $stable(s3_vld_q) && $stable(s6_vld_q))
    else $error("pipeline moved while frozen");

  a_lanes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    xd_vld == yd_vld)
    else $error("axis dividers out of step");

endmodule

>>> tb/radial_stick_deadzone_tb.sv
// ----------------------------------------------------------------------------
// radial_stick_deadzone_tb: self-checking bench for the radial deadzone
// Drives stick samples with random gaps, stalls the result side at random,
// predicts each result from the deadzone settings and compares field by
// field. Runs directed corners and random sweeps under several settings.
// ----------------------------------------------------------------------------
module radial_stick_deadzone_tb;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LATENCY        = 60;
  localparam int EXP_DEPTH      = 2048;

  typedef struct packed {
    logic [rsd_pkg::AXIS_W-1:0] x;
    logic [rsd_pkg::AXIS_W-1:0] y;
    logic                       dz;
  } stick_res_t;

  logic                          clk_i;
  logic                          rst_ni;
  logic                          in_valid_i;
  logic                          in_stall_o;
  logic [rsd_pkg::AXIS_W-1:0]    stick_x_i;
  logic [rsd_pkg::AXIS_W-1:0]    stick_y_i;
  logic                          out_valid_o;
  logic                          out_stall_i;
  logic [rsd_pkg::AXIS_W-1:0]    out_x_o;
  logic [rsd_pkg::AXIS_W-1:0]    out_y_o;
  logic                          in_deadzone_o;
  logic                          cfg_valid_i;
  logic                          cfg_ready_o;
  logic [rsd_pkg::CFG_IDX_W-1:0] cfg_index_i;
  logic [rsd_pkg::DZ_W-1:0]      cfg_data_i;

  logic [rsd_pkg::DZ_W-1:0] inner_q;
  logic [rsd_pkg::DZ_W-1:0] outer_q;
  stick_res_t      exp_mem [EXP_DEPTH];
  int              exp_wr;
  int              exp_rd;
  int              rx_wait;
  int              n_sent;
  int              n_recv;
  int              n_dz;
  int              n_mismatch;
  int              idle_cycles;
  bit              rx_stall_en;

  radial_stick_deadzone u_top (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [rsd_pkg::AXIS_W-1:0] scale_rail(longint a, longint norm,
                                                             longint mag);
    longint m;
    longint q;
    longint r;
    m = (a < 0) ? -a : a;
    q = (m * norm) / mag;
    if (a < 0) r = (q > 32768) ? -32768 : -q;
    else r = (q > 32767) ? 32767 : q;
    return r[rsd_pkg::AXIS_W-1:0];
  endfunction

  function automatic longint isqrt(longint v);
    longint res;
    longint rem;
    longint bit_v;
    res   = 0;
    rem   = v;
    bit_v = longint'(1) <<< 62;
    while (bit_v > rem) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (rem >= res + bit_v) begin
        rem = rem - res - bit_v;
        res = (res >>> 1) + bit_v;
      end else begin
        res = res >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return res;
  endfunction

  function automatic stick_res_t deadzone_map(logic [rsd_pkg::AXIS_W-1:0] sx,
                                              logic [rsd_pkg::AXIS_W-1:0] sy);
    stick_res_t res;
    longint x;
    longint y;
    longint sumsq;
    longint inner;
    longint outer;
    longint mag;
    longint norm;
    x = longint'($signed(sx));
    y = longint'($signed(sy));
    sumsq = x * x + y * y;
    inner = inner_q;
    outer = outer_q;
    res = '0;
    if (sumsq <= inner * inner) begin
      res.dz = 1'b1;
      return res;
    end
    mag = isqrt(sumsq);
    norm = ((mag - inner) <<< rsd_pkg::FRAC) / (32768 - outer - inner);
    if (norm > 32768) norm = 32768;
    res.x = scale_rail(x, norm, mag);
    res.y = scale_rail(y, norm, mag);
    return res;
  endfunction

  // hold the result side for a drawn number of cycles after each beat
  always @(posedge clk_i) begin
    int w;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) begin
        w = rx_stall_en ? $urandom_range(0, 3) : 0;
        rx_wait     <= w;
        out_stall_i <= (w != 0);
      end else if (out_stall_i) begin
        if (rx_wait <= 1) begin
          rx_wait     <= 0;
          out_stall_i <= 1'b0;
        end else begin
          rx_wait <= rx_wait - 1;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    stick_res_t got;
    stick_res_t exp_r;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = '{x: out_x_o, y: out_y_o, dz: in_deadzone_o};
      n_recv++;
      if (exp_wr == exp_rd) begin
        n_mismatch++;
        if (n_mismatch <= 10) $display("unexpected beat: %p", got);
      end else begin
        exp_r = exp_mem[exp_rd % EXP_DEPTH];
        exp_rd++;
        if (got !== exp_r) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("mismatch: exp x=%h y=%h dz=%b got x=%h y=%h dz=%b",
                     exp_r.x, exp_r.y, exp_r.dz, got.x, got.y, got.dz);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog timeout");
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic send_sample(logic [rsd_pkg::AXIS_W-1:0] sx, logic [rsd_pkg::AXIS_W-1:0] sy,
                             bit gaps);
    int gap;
    stick_res_t exp_r;
    gap = gaps ? $urandom_range(0, 3) : 0;
    exp_r = deadzone_map(sx, sy);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    stick_x_i  <= sx;
    stick_y_i  <= sy;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    exp_mem[exp_wr % EXP_DEPTH] = exp_r;
    exp_wr++;
    n_sent++;
    if (exp_r.dz) n_dz++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [rsd_pkg::CFG_IDX_W-1:0] idx, logic [rsd_pkg::DZ_W-1:0] val);
    drain_results();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    if (idx == rsd_pkg::REG_INNER) inner_q = val;
    else if (idx == rsd_pkg::REG_OUTER) outer_q = val;
  endtask

  task automatic test_directed();
    logic [rsd_pkg::AXIS_W-1:0] corner[6];
    logic [rsd_pkg::AXIS_W-1:0] r;
    corner = '{16'h8000, 16'h7fff, 16'h0000, 16'h0001, 16'hffff, 16'h2666};
    foreach (corner[i]) send_sample(corner[i], corner[(i + 2) % 6], 1'b0);
    send_sample(16'h2666, 16'h0000, 1'b1);
    send_sample(16'h2667, 16'h0000, 1'b1);
    send_sample(16'h1b2d, 16'h1b2d, 1'b1);
    send_sample(16'h8000, 16'h8000, 1'b1);
    send_sample(16'h7fff, 16'h7fff, 1'b1);
    send_sample(16'h5a82, 16'ha57e, 1'b1);
    r = 16'(9830);
    send_sample(-r, 16'h0000, 1'b1);
    send_sample(16'h0000, -(r + 16'd1), 1'b1);
    send_sample(16'h6000, 16'h0000, 1'b1);
  endtask

  task automatic test_random(int count);
    logic [rsd_pkg::AXIS_W-1:0] sx;
    logic [rsd_pkg::AXIS_W-1:0] sy;
    int near;
    for (int i = 0; i < count; i++) begin
      near = inner_q + $urandom_range(0, 8) - 4;
      case ($urandom_range(0, 3))
        0: begin
          sx = rsd_pkg::AXIS_W'(near);
          sy = rsd_pkg::AXIS_W'($urandom_range(0, 40));
          if ($urandom_range(0, 1)) sx = -sx;
        end
        1: begin
          sx = rsd_pkg::AXIS_W'($urandom_range(0, 2 * inner_q + 8) - inner_q - 4);
          sy = rsd_pkg::AXIS_W'($urandom_range(0, 2 * inner_q + 8) - inner_q - 4);
        end
        default: begin
          sx = rsd_pkg::AXIS_W'($urandom);
          sy = rsd_pkg::AXIS_W'($urandom);
        end
      endcase
      send_sample(sx, sy, i % 200 < 150);
    end
  endtask

  task automatic test_settings();
    write_reg(rsd_pkg::REG_INNER, 14'd0);
    write_reg(rsd_pkg::REG_OUTER, 14'd0);
    test_random(150);
    write_reg(rsd_pkg::REG_INNER, 14'h3fff);
    write_reg(rsd_pkg::REG_OUTER, 14'h3fff);
    test_directed();
    test_random(150);
    write_reg(rsd_pkg::REG_INNER, rsd_pkg::DZ_W'($urandom));
    write_reg(rsd_pkg::REG_OUTER, rsd_pkg::DZ_W'($urandom));
    test_random(150);
    write_reg(rsd_pkg::REG_INNER, 14'd1);
    write_reg(rsd_pkg::REG_OUTER, 14'h3fff);
    test_random(100);
    write_reg(rsd_pkg::REG_INNER, rsd_pkg::INNER_RST);
    write_reg(rsd_pkg::REG_OUTER, rsd_pkg::OUTER_RST);
  endtask

  task automatic test_backpressure();
    rx_stall_en = 1'b0;
    test_random(100);
    rx_stall_en = 1'b1;
    test_random(50);
    in_valid_i <= 1'b0;
    while (exp_wr != exp_rd) @(posedge clk_i);
    test_random(250);
  endtask

  initial begin
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    stick_x_i   = '0;
    stick_y_i   = '0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = rsd_pkg::REG_INNER;
    cfg_data_i  = '0;
    inner_q     = rsd_pkg::INNER_RST;
    outer_q     = rsd_pkg::OUTER_RST;
    exp_wr = 0; exp_rd = 0; rx_wait = 0;
    n_sent = 0; n_recv = 0; n_dz = 0; n_mismatch = 0; idle_cycles = 0;
    rx_stall_en = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(150);
    test_settings();
    test_backpressure();
    drain_results();
    $display("Covered %0d samples (%0d in deadzone), %0d beats checked,",
             n_sent, n_dz, n_recv);
    $display("over five deadzone settings with random gaps and stalls.");
    if (n_mismatch == 0 && exp_wr == exp_rd) begin
      $display("Regression PASS");
    end else begin
      $display("%0d mismatches, %0d left over", n_mismatch, exp_wr - exp_rd);
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
